[rtl/iisl_pkg.sv]
// shared types and codes for the indexed insert/erase list unit
// no dependencies; used by iisl_store, iisl_seq and the top level
`default_nettype none

package iisl_pkg;

	// default number of list entries held in the store
	localparam int CAPACITY_DEF = 256;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int POS_W   = 9;
	localparam int COUNT_OUT_W = 9;
	localparam int STATUS_W = 2;

	// request kinds
	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_ERASE  = 2'd2,
		REQ_READ   = 2'd3
	} req_kind_t;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		req_kind_t                  req_type;
		logic [POS_W-1:0]           position;
		logic signed [VALUE_W-1:0]  item_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  read_value;
		logic [STATUS_W-1:0]        status;
		logic [COUNT_OUT_W-1:0]     entry_count;
	} res_t;

endpackage

`default_nettype wire

[rtl/iisl_store.sv]
// entry store of the list: one write port, one read port with registered data
// depends on iisl_pkg for the value width
`default_nettype none

module iisl_store #(
	parameter int DEPTH = iisl_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [AW-1:0]                    waddr,
	input  wire logic [iisl_pkg::VALUE_W-1:0]     wdata,
	input  wire logic [AW-1:0]                    raddr,
	output logic      [iisl_pkg::VALUE_W-1:0]     rdata
);

	logic [iisl_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [iisl_pkg::VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/iisl_seq.sv]
// request sequencer: decodes a request, walks the shared index stepper over
// the store one entry per read/write pair, keeps the fill count
// depends on iisl_pkg
`default_nettype none

module iisl_seq #(
	parameter int CAPACITY = iisl_pkg::CAPACITY_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	input  wire iisl_pkg::req_t                     req,
	output logic                                    ready,
	output logic                                    res_valid,
	output iisl_pkg::res_t                          res,
	input  wire logic                               res_take,
	output logic                                    mem_we,
	output logic [$clog2(CAPACITY)-1:0]             mem_waddr,
	output logic [iisl_pkg::VALUE_W-1:0]            mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]             mem_raddr,
	input  wire logic [iisl_pkg::VALUE_W-1:0]       mem_rdata
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > iisl_pkg::POS_W) ? CW : iisl_pkg::POS_W;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_SH_RD   = 7'b0000010,
		S_SH_WR   = 7'b0000100,
		S_PUT     = 7'b0001000,
		S_RD_ADDR = 7'b0010000,
		S_RD_DATA = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t                            state_q;
	logic [AW-1:0]                     idx_q;
	logic [AW-1:0]                     bound_q;
	logic                              shift_up_q;
	logic [iisl_pkg::VALUE_W-1:0]      val_q;
	logic [CW-1:0]                     count_q;
	logic [iisl_pkg::STATUS_W-1:0]     st_q;
	logic [iisl_pkg::VALUE_W-1:0]      rd_q;

	logic [AW-1:0]     step;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  cnt_w;
	logic              full;

	// shared index stepper: down for an insert shift, up for an erase shift
	assign step  = shift_up_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
	assign pos_w = CMP_W'(req.position);
	assign cnt_w = CMP_W'(count_q);
	assign full  = (count_q == CW'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						case (req.req_type)
							iisl_pkg::REQ_APPEND: begin
								state_q <= full ? S_DONE : S_PUT;
							end
							iisl_pkg::REQ_INSERT: begin
								if (pos_w > cnt_w || full) begin
									state_q <= S_DONE;
								end else if (pos_w == cnt_w) begin
									state_q <= S_PUT;
								end else begin
									state_q <= S_SH_RD;
								end
							end
							iisl_pkg::REQ_ERASE: begin
								if (pos_w >= cnt_w) begin
									state_q <= S_DONE;
								end else if (pos_w == cnt_w - CMP_W'(1)) begin
									// last entry: nothing to move
									count_q <= count_q - CW'(1);
									state_q <= S_DONE;
								end else begin
									state_q <= S_SH_RD;
								end
							end
							iisl_pkg::REQ_READ: begin
								state_q <= (pos_w >= cnt_w) ? S_DONE : S_RD_ADDR;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					if (step == bound_q) begin
						if (shift_up_q) begin
							state_q <= S_PUT;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_RD_ADDR: state_q <= S_RD_DATA;
				S_RD_DATA: state_q <= S_DONE;
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					val_q <= req.item_value;
					rd_q  <= '0;
					st_q  <= iisl_pkg::ST_OK;
					case (req.req_type)
						iisl_pkg::REQ_APPEND: begin
							idx_q <= count_q[AW-1:0];
							if (full) begin
								st_q <= iisl_pkg::ST_FULL;
							end
						end
						iisl_pkg::REQ_INSERT: begin
							shift_up_q <= 1'b1;
							bound_q    <= pos_w[AW-1:0];
							if (pos_w > cnt_w) begin
								st_q <= iisl_pkg::ST_BAD;
							end else if (full) begin
								st_q <= iisl_pkg::ST_FULL;
							end else if (pos_w == cnt_w) begin
								idx_q <= pos_w[AW-1:0];
							end else begin
								idx_q <= count_q[AW-1:0];
							end
						end
						iisl_pkg::REQ_ERASE: begin
							shift_up_q <= 1'b0;
							idx_q      <= pos_w[AW-1:0];
							bound_q    <= count_q[AW-1:0] - AW'(1);
							if (pos_w >= cnt_w) begin
								st_q <= iisl_pkg::ST_BAD;
							end
						end
						iisl_pkg::REQ_READ: begin
							idx_q <= pos_w[AW-1:0];
							if (pos_w >= cnt_w) begin
								st_q <= iisl_pkg::ST_BAD;
							end
						end
						default: st_q <= iisl_pkg::ST_BAD;
					endcase
				end
			end
			S_SH_WR: idx_q <= step;
			S_RD_DATA: rd_q <= mem_rdata;
			default: ;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = idx_q;
		case (state_q)
			S_SH_RD: mem_raddr = step;
			S_SH_WR: mem_we = 1'b1;
			S_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = val_q;
			end
			default: ;
		endcase
	end

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.read_value  = rd_q;
	assign res.status      = st_q;
	assign res.entry_count = cnt_w[iisl_pkg::COUNT_OUT_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1)
			|| count_q == $past(count_q) - CW'(1)))
		else $error("fill count moved by more than one");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && ready) |=> !ready)
		else $error("sequencer still idle after taking a request");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SH_WR || state_q == S_PUT))
		else $error("store written outside a write step");

endmodule

`default_nettype wire

[rtl/indexed_insert_erase_list_unit.sv]
// top level of the indexed insert/erase list unit: stream ports, output register
// depends on iisl_pkg, iisl_store and iisl_seq
//
// channel | dir | tdata fields (lsb first)                         | tuser
// s_*     | in  | position[8:0], item_value[40:9], zero pad to 48  | req_type[1:0]
// m_*     | out | read_value[31:0], status[33:32], entry_count[42:34], zero pad | none
//
// steps: a rejected request, or one that erases the last entry, goes straight to its
// result; an append or an insert at the end writes the item, a read sets the address
// and then takes the data, an insert that shifts entries moves them and then writes
// the item, an erase that shifts them only moves them; with one read and one write
// port, each moved entry gets a read step and a write step from the shared stepper
// reset: arst_n clears the fill count and the control state; the store is not
// cleared, entries above the count are never read
// stalls: s_tready is low while a request is in work; a result waiting on m_tready
// does not block the next request until that request is ready to deliver
`default_nettype none

module indexed_insert_erase_list_unit #(
	parameter int CAPACITY = iisl_pkg::CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // position[8:0], item_value[40:9]
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	// result channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // read_value[31:0], status[33:32], entry_count[42:34]
);

	localparam int AW = $clog2(CAPACITY);

	iisl_pkg::req_t  req;
	iisl_pkg::res_t  res;
	logic            seq_ready;
	logic            res_valid;
	logic            res_take;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [iisl_pkg::VALUE_W-1:0]  mem_wdata;
	logic [AW-1:0]                 mem_raddr;
	logic [iisl_pkg::VALUE_W-1:0]  mem_rdata;

	// output register, decouples the result from the downstream stall
	logic            m_tvalid_q;
	iisl_pkg::res_t  m_res_q;

	// unpack the request transaction
	assign req.req_type   = iisl_pkg::req_kind_t'(s_tuser);
	assign req.position   = s_tdata[8:0];
	assign req.item_value = s_tdata[40:9];

	assign s_tready = seq_ready;

	// a finished result moves into the output register when it is free
	// or being emptied in the same cycle
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	iisl_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req       (req),
		.ready     (seq_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	iisl_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, m_res_q.entry_count, m_res_q.status, m_res_q.read_value};

	// a result handed over is presented on the next cycle
	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> m_tvalid)
		else $error("result taken but not presented");

	// no result is taken while the output register holds an unread one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !res_take)
		else $error("pending result overwritten");

	// a new request is taken only while no result waits in the sequencer
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !res_valid)
		else $error("request taken with a result still pending");

endmodule

`default_nettype wire
